@@ hdl/vlgd_pkg.sv @@
// shared types and constants for the video line group decoder
package vlgd_pkg;

   localparam int GroupsPerLineDefault = 48;
   localparam int GroupIndexWidth      = 6;
   localparam int PixelCountWidth      = 5;

   // one expansion job: a run (mask all zero) or a two-colour mask pattern
   typedef struct packed {
      logic [7:0] colour_zero;
      logic [7:0] colour_one;
      logic [7:0] mask;
      logic       pair;        // one pixel per mask bit instead of two
      logic [3:0] last_index;  // pixel count of the job minus one
      logic       group_end;
      logic       line_end;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_load_type;

endpackage

@@ hdl/vlgd_decode.sv @@
// group state tracking and byte decode into pixel expansion jobs
module vlgd_decode #(
   parameter int GROUPS_PER_LINE = vlgd_pkg::GroupsPerLineDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             code_byte,
   output vlgd_pkg::job_load_type load
);

   localparam int GW = vlgd_pkg::GroupIndexWidth;
   localparam int PW = vlgd_pkg::PixelCountWidth;
   localparam logic [GW-1:0] LastGroup = GW'(GROUPS_PER_LINE - 1);

   localparam logic [7:0] ModeByteFill     = 8'h01;
   localparam logic [7:0] ModeByteHalf     = 8'h02;
   localparam logic [7:0] ModeByteMaskWide = 8'h03;
   localparam logic [7:0] ModeByteQuarter  = 8'h04;
   localparam logic [7:0] ModeByteMaskPair = 8'h06;
   localparam logic [7:0] ModeByteEighth   = 8'h08;
   localparam logic [7:0] ModeByteRaw      = 8'h10;

   localparam logic [1:0] PhaseColourZero = 2'd0;
   localparam logic [1:0] PhaseColourOne  = 2'd1;
   localparam logic [1:0] PhaseMask       = 2'd2;

   typedef enum logic [7:0] {
      MODE_IDLE      = 8'b0000_0001,
      MODE_FILL      = 8'b0000_0010,
      MODE_HALF      = 8'b0000_0100,
      MODE_QUARTER   = 8'b0000_1000,
      MODE_EIGHTH    = 8'b0001_0000,
      MODE_RAW       = 8'b0010_0000,
      MODE_MASK_WIDE = 8'b0100_0000,
      MODE_MASK_PAIR = 8'b1000_0000
   } group_mode_type;

   group_mode_type mode_ff, mode_in;
   logic [GW-1:0]  group_index_ff, group_index_in;
   logic [1:0]     phase_ff, phase_in;
   logic [PW-1:0]  pixels_ff, pixels_in;
   logic [7:0]     colour_zero_ff, colour_zero_in;
   logic [7:0]     colour_one_ff, colour_one_in;

   logic [PW-1:0]     pixel_base;
   logic [PW-1:0]     run_len;
   logic [PW-1:0]     pixel_sum;
   logic              group_done;
   vlgd_pkg::job_type job;
   logic              job_valid;

   always_comb begin
      mode_in        = mode_ff;
      group_index_in = group_index_ff;
      phase_in       = phase_ff;
      pixels_in      = pixels_ff;
      colour_zero_in = colour_zero_ff;
      colour_one_in  = colour_one_ff;
      pixel_base     = pixels_ff;
      run_len        = '0;
      job            = '0;
      job_valid      = 1'b0;

      case (mode_ff)
         MODE_IDLE: begin
            pixel_base = '0;
            pixels_in  = '0;
            phase_in   = PhaseColourZero;
            case (code_byte)
               ModeByteFill:     mode_in = MODE_FILL;
               ModeByteHalf:     mode_in = MODE_HALF;
               ModeByteQuarter:  mode_in = MODE_QUARTER;
               ModeByteEighth:   mode_in = MODE_EIGHTH;
               ModeByteRaw:      mode_in = MODE_RAW;
               ModeByteMaskWide: mode_in = MODE_MASK_WIDE;
               ModeByteMaskPair: mode_in = MODE_MASK_PAIR;
               default: begin
                  // unknown mode: a whole group of zero pixels at once
                  job_valid = 1'b1;
                  run_len   = PW'(16);
               end
            endcase
         end
         MODE_FILL: begin
            job_valid        = 1'b1;
            run_len          = PW'(16);
            job.colour_zero  = code_byte;
         end
         MODE_HALF: begin
            job_valid        = 1'b1;
            run_len          = PW'(8);
            job.colour_zero  = code_byte;
         end
         MODE_QUARTER: begin
            job_valid        = 1'b1;
            run_len          = PW'(4);
            job.colour_zero  = code_byte;
         end
         MODE_EIGHTH: begin
            job_valid        = 1'b1;
            run_len          = PW'(2);
            job.colour_zero  = code_byte;
         end
         MODE_RAW: begin
            job_valid        = 1'b1;
            run_len          = PW'(1);
            job.colour_zero  = code_byte;
         end
         MODE_MASK_WIDE, MODE_MASK_PAIR: begin
            case (phase_ff)
               PhaseColourZero: begin
                  colour_zero_in = code_byte;
                  phase_in       = PhaseColourOne;
               end
               PhaseColourOne: begin
                  colour_one_in = code_byte;
                  phase_in      = PhaseMask;
               end
               default: begin
                  phase_in        = PhaseColourZero;
                  job_valid       = 1'b1;
                  job.colour_zero = colour_zero_ff;
                  job.colour_one  = colour_one_ff;
                  job.mask        = code_byte;
                  job.pair        = (mode_ff == MODE_MASK_PAIR);
                  run_len         = (mode_ff == MODE_MASK_PAIR) ? PW'(8) : PW'(16);
               end
            endcase
         end
         default: mode_in = MODE_IDLE;
      endcase

      pixel_sum      = pixel_base + run_len;
      job.last_index = 4'(run_len - PW'(1));
      group_done     = job_valid && pixel_sum[PW-1];
      job.group_end  = group_done;
      job.line_end   = group_done && (group_index_ff == LastGroup);

      if (job_valid) begin
         pixels_in = pixel_sum;
      end
      if (group_done) begin
         mode_in   = MODE_IDLE;
         phase_in  = PhaseColourZero;
         pixels_in = '0;
         if (group_index_ff == LastGroup) begin
            group_index_in = '0;
            colour_zero_in = '0;
            colour_one_in  = '0;
         end else begin
            group_index_in = group_index_ff + GW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         group_index_ff <= '0;
         phase_ff       <= PhaseColourZero;
         pixels_ff      <= '0;
         colour_zero_ff <= '0;
         colour_one_ff  <= '0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         group_index_ff <= group_index_in;
         phase_ff       <= phase_in;
         pixels_ff      <= pixels_in;
         colour_zero_ff <= colour_zero_in;
         colour_one_ff  <= colour_one_in;
      end
   end

   assign load.valid = job_valid;
   assign load.job   = job;

   a_group_index_range: assert property (@(posedge clock) disable iff (reset)
      group_index_ff <= LastGroup)
      else $error("group index beyond last group");

   a_pixels_below_group: assert property (@(posedge clock) disable iff (reset)
      pixels_ff < PW'(16))
      else $error("pixel count reached a full group without ending it");

   a_line_end_on_group_end: assert property (@(posedge clock) disable iff (reset)
      load.valid && load.job.line_end |-> load.job.group_end)
      else $error("line end without group end");

endmodule

@@ hdl/vlgd_expand.sv @@
// job register that drains one pixel per cycle into the result register while the result register is empty or taken
module vlgd_expand (
   input  logic                   clock,
   input  logic                   reset,
   input  vlgd_pkg::job_load_type load,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   accept,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_pixel,
   output logic                   rsp_group_end,
   output logic                   rsp_line_end
);

   vlgd_pkg::job_type job_ff;
   logic              job_valid_ff, job_valid_in;
   logic [3:0]        count_ff, count_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_pixel_ff, out_pixel_in;
   logic              out_group_end_ff, out_group_end_in;
   logic              out_line_end_ff, out_line_end_in;

   logic       out_ready;
   logic       emit;
   logic       job_last;
   logic       job_done;
   logic [2:0] bit_index;
   logic       bit_select;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign emit      = job_valid_ff && out_ready;
   assign job_last  = (count_ff == job_ff.last_index);
   assign job_done  = emit && job_last;
   assign req_stall = job_valid_ff && !job_done;
   assign accept    = req_valid && !req_stall;

   // mask bits from the msb down, two pixels per bit unless pair mode
   assign bit_index  = job_ff.pair ? count_ff[2:0] : count_ff[3:1];
   assign bit_select = job_ff.mask[3'd7 - bit_index];

   always_comb begin
      job_valid_in = job_valid_ff;
      count_in     = count_ff;
      if (accept) begin
         job_valid_in = load.valid;
         count_in     = '0;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         count_in = count_ff + 4'd1;
      end

      out_valid_in     = out_valid_ff;
      out_pixel_in     = out_pixel_ff;
      out_group_end_in = out_group_end_ff;
      out_line_end_in  = out_line_end_ff;
      if (out_ready) begin
         out_valid_in     = emit;
         out_pixel_in     = bit_select ? job_ff.colour_one : job_ff.colour_zero;
         out_group_end_in = job_last && job_ff.group_end;
         out_line_end_in  = job_last && job_ff.line_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= load.job;
      end
      out_pixel_ff     <= out_pixel_in;
      out_group_end_ff <= out_group_end_in;
      out_line_end_ff  <= out_line_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel     = out_pixel_ff;
   assign rsp_group_end = out_group_end_ff;
   assign rsp_line_end  = out_line_end_ff;

   a_count_in_job: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> count_ff <= job_ff.last_index)
      else $error("pixel count ran past the end of the job");

   a_load_starts_job: assert property (@(posedge clock) disable iff (reset)
      accept && load.valid |=> job_valid_ff && count_ff == 4'd0)
      else $error("accepted job not loaded");

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> job_valid_ff)
      else $error("input stalled with no job pending");

endmodule

@@ hdl/video_line_group_decoder.sv @@
// top level of the video line group decoder
//
// req channel: one encoded line byte per word (mode byte or payload byte),
// taken at an edge with req_valid high and req_stall low. rsp channel: one
// decoded pixel per word with group_end on the sixteenth pixel of a group
// and line_end on the last pixel of the line, taken with rsp_valid high and
// rsp_stall low.
// a byte taken on req is loaded into the job register, and its pixels
// then pass through the rsp register on their way out.
// while the rsp register is empty or taken, the job register drains one
// pixel per cycle into it and raw pixel bytes stream at one per cycle; a
// byte that expands to k pixels (1 to 16) holds req until its last pixel
// moves, and mode and colour bytes that give no pixel do not hold req.
// a new byte is taken in the same cycle that the last pixel of the current
// job moves to the rsp register, which needs that register empty or taken.
// when rsp_valid and rsp_stall are high the rsp word holds and the job register stops;
// req_stall is high while a job is pending and its last pixel is not moving.
// reset clears group index, mode, counters and both valid flags; the next
// byte is read as the mode byte of group zero.
module video_line_group_decoder #(
   parameter int GROUPS_PER_LINE = vlgd_pkg::GroupsPerLineDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_code_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pixel,
   output logic       rsp_group_end,
   output logic       rsp_line_end
);

   // decode result for the byte on req, valid when it expands to pixels
   vlgd_pkg::job_load_type load;
   logic                   accept;

   // group state and byte decode, updated only on a taken req word
   vlgd_decode #(
      .GROUPS_PER_LINE (GROUPS_PER_LINE)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .code_byte (req_code_byte),
      .load      (load)
   );

   // pixel expansion and the rsp register
   vlgd_expand u_expand (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .accept        (accept),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel     (rsp_pixel),
      .rsp_group_end (rsp_group_end),
      .rsp_line_end  (rsp_line_end)
   );

endmodule

@@ test/video_line_group_decoder_tb.sv @@
// self-checking testbench for the video line group decoder
module video_line_group_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_GROUPS      = vlgd_pkg::GroupsPerLineDefault;
   localparam int PIXELS_PER_GROUP = 16;
   localparam int TOTAL_ITEMS      = 370;    // minimum number of encoded bytes offered in the whole run
   localparam int TAIL_ITEMS       = 50;     // last bytes sent with no idling on either side
   localparam int HOLD_AT          = 120;    // bytes taken before the long rsp hold-off
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 40;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int PRINT_LIMIT      = 40;

   // mode byte codes on the wire
   localparam logic [7:0] CODE_FILL      = 8'h01;
   localparam logic [7:0] CODE_HALF      = 8'h02;
   localparam logic [7:0] CODE_MASK_WIDE = 8'h03;
   localparam logic [7:0] CODE_QUARTER   = 8'h04;
   localparam logic [7:0] CODE_MASK_PAIR = 8'h06;
   localparam logic [7:0] CODE_EIGHTH    = 8'h08;
   localparam logic [7:0] CODE_RAW       = 8'h10;

   // decoding state of the current group
   typedef enum logic [2:0] {
      MODE_AWAIT,
      MODE_FILL,
      MODE_HALF,
      MODE_QUARTER,
      MODE_EIGHTH,
      MODE_RAW,
      MODE_MASK_WIDE,
      MODE_MASK_PAIR
   } group_mode_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       group_end;
      logic       line_end;
   } pixel_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_code_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_pixel;
   logic       rsp_group_end;
   logic       rsp_line_end;

   video_line_group_decoder #(
      .GROUPS_PER_LINE(LINE_GROUPS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_byte (req_code_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel     (rsp_pixel),
      .rsp_group_end (rsp_group_end),
      .rsp_line_end  (rsp_line_end)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // encoded bytes still to be offered, and pixels still owed by the block
   logic [7:0]     line_bytes[$];
   pixel_word_type expected_pixels[$];

   int unsigned total_bytes = 0;
   int unsigned bytes_taken = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   logic        quiet_tail = 1'b0;

   // ---------------------------------------------------------------
   // line decoder prediction: own copy of the group state
   // ---------------------------------------------------------------
   logic [vlgd_pkg::GroupIndexWidth-1:0] grp_num;
   group_mode_type                       grp_mode;
   logic [4:0]                           payload_seen;
   logic [7:0]                           col_lo;
   logic [7:0]                           col_hi;
   logic [vlgd_pkg::PixelCountWidth-1:0] grp_pixels;

   function automatic void clear_decoder();
      grp_num      = '0;
      grp_mode     = MODE_AWAIT;
      payload_seen = '0;
      col_lo       = '0;
      col_hi       = '0;
      grp_pixels   = '0;
   endfunction

   // one pixel out; closes the group on the sixteenth and the line on the last group
   function automatic void emit_pixel(input logic [7:0] value);
      pixel_word_type w;
      w.pixel     = value;
      w.group_end = 1'b0;
      w.line_end  = 1'b0;
      grp_pixels  = grp_pixels + 1'b1;
      if (grp_pixels >= PIXELS_PER_GROUP) begin
         w.group_end = 1'b1;
         if (int'(grp_num) + 1 >= LINE_GROUPS) begin
            w.line_end = 1'b1;
            clear_decoder();
         end else begin
            grp_num      = grp_num + 1'b1;
            grp_mode     = MODE_AWAIT;
            payload_seen = '0;
            grp_pixels   = '0;
         end
      end
      expected_pixels.push_back(w);
   endfunction

   function automatic void emit_run(input logic [7:0] value, input int len);
      for (int i = 0; i < len; i++) begin
         emit_pixel(value);
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] code);
      logic [7:0] lo;
      logic [7:0] hi;
      int         phase;
      lo = col_lo;
      hi = col_hi;
      case (grp_mode)
         MODE_AWAIT: begin
            payload_seen = '0;
            grp_pixels   = '0;
            case (code)
               CODE_FILL:      grp_mode = MODE_FILL;
               CODE_HALF:      grp_mode = MODE_HALF;
               CODE_QUARTER:   grp_mode = MODE_QUARTER;
               CODE_EIGHTH:    grp_mode = MODE_EIGHTH;
               CODE_RAW:       grp_mode = MODE_RAW;
               CODE_MASK_WIDE: grp_mode = MODE_MASK_WIDE;
               CODE_MASK_PAIR: grp_mode = MODE_MASK_PAIR;
               // unknown mode: a blank group right away
               default:        emit_run(8'h00, PIXELS_PER_GROUP);
            endcase
         end
         MODE_FILL:    emit_run(code, 16);
         MODE_HALF:    emit_run(code, 8);
         MODE_QUARTER: emit_run(code, 4);
         MODE_EIGHTH:  emit_run(code, 2);
         MODE_RAW:     emit_pixel(code);
         MODE_MASK_WIDE, MODE_MASK_PAIR: begin
            // colour, colour, mask; the mask expands msb first
            phase        = int'(payload_seen) % 3;
            payload_seen = payload_seen + 1'b1;
            if (phase == 0) begin
               col_lo = code;
            end else if (phase == 1) begin
               col_hi = code;
            end else begin
               for (int b = 7; b >= 0; b--) begin
                  emit_run(code[b] ? hi : lo, (grp_mode == MODE_MASK_WIDE) ? 2 : 1);
               end
            end
         end
         default: grp_mode = MODE_AWAIT;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   function automatic logic is_mode_code(input logic [7:0] code);
      case (code)
         CODE_FILL, CODE_HALF, CODE_QUARTER, CODE_EIGHTH,
         CODE_RAW, CODE_MASK_WIDE, CODE_MASK_PAIR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // mode byte followed by random payload
   function automatic void add_group(input logic [7:0] code, input int payload_len);
      line_bytes.push_back(code);
      for (int i = 0; i < payload_len; i++) begin
         line_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void add_random_group();
      int         pick;
      logic [7:0] odd_code;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         // stray byte, shifts the framing of what follows
         line_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 25) begin
         odd_code = 8'($urandom_range(0, 255));
         while (is_mode_code(odd_code)) begin
            odd_code = 8'($urandom_range(0, 255));
         end
         line_bytes.push_back(odd_code);
      end else if (pick < 40) begin
         add_group(CODE_FILL, 1);
      end else if (pick < 52) begin
         add_group(CODE_HALF, 2);
      end else if (pick < 62) begin
         add_group(CODE_QUARTER, 4);
      end else if (pick < 70) begin
         add_group(CODE_EIGHTH, 8);
      end else if (pick < 76) begin
         add_group(CODE_RAW, 16);
      end else if (pick < 90) begin
         add_group(CODE_MASK_WIDE, 3);
      end else begin
         add_group(CODE_MASK_PAIR, 6);
      end
   endfunction

   // ---------------------------------------------------------------
   // mismatch reporting
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // ---------------------------------------------------------------
   // req driver: offers queued bytes, idles in short bursts, holds the
   // word while stalled; every taken byte goes through the prediction
   // ---------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_code_byte <= 8'h00;
         send_gap = 0;
         clear_decoder();
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_code_byte);
            bytes_taken <= bytes_taken + 1;
         end
         // a new word only once the current one has gone (or there is none)
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (line_bytes.size() != 0 &&
                         (quiet_tail || $urandom_range(0, 5) != 0)) begin
               req_valid     <= 1'b1;
               req_code_byte <= line_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
               // idle burst, lengthened by a random send_gap
               if (line_bytes.size() != 0) send_gap = $urandom_range(0, 3);
            end
         end
         quiet_tail <= (line_bytes.size() < TAIL_ITEMS);
      end
   end

   // ---------------------------------------------------------------
   // rsp stall: random bursts, plus one long hold-off so the block backs
   // up and stalls req while the driver keeps offering
   // ---------------------------------------------------------------
   int  stall_run = 0;
   int  hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (!hold_done && bytes_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_run = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // rsp monitor: each taken pixel word against the oldest expected one
   // ---------------------------------------------------------------
   pixel_word_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("pixel %02h with nothing expected", rsp_pixel));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel !== want.pixel)
               report_mismatch($sformatf("pixel %02h, want %02h", rsp_pixel, want.pixel));
            if (rsp_group_end !== want.group_end)
               report_mismatch($sformatf("group_end %b, want %b",
                                         rsp_group_end, want.group_end));
            if (rsp_line_end !== want.line_end)
               report_mismatch($sformatf("line_end %b, want %b",
                                         rsp_line_end, want.line_end));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding",
                  cycle_count, expected_pixels.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // sequence: build the byte stream, release reset, wait for the drain
   // ---------------------------------------------------------------
   initial begin
      // unknown modes at both ends of the byte range: blank groups
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      // single colour, then two colours at the extremes
      line_bytes.push_back(CODE_FILL);
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(CODE_HALF);
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      // four colours, each a single-bit or near-full pattern
      line_bytes.push_back(CODE_QUARTER);
      line_bytes.push_back(8'h01);
      line_bytes.push_back(8'h80);
      line_bytes.push_back(8'h7F);
      line_bytes.push_back(8'hFE);
      // wide mask: two pixels per mask bit
      line_bytes.push_back(CODE_MASK_WIDE);
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(8'hA5);
      // paired masks: all-zero mask then all-one mask
      line_bytes.push_back(CODE_MASK_PAIR);
      line_bytes.push_back(8'h11);
      line_bytes.push_back(8'hEE);
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'h5A);
      line_bytes.push_back(8'hC3);
      line_bytes.push_back(8'hFF);
      // random groups, long enough to cross the end of a line
      while (line_bytes.size() < TOTAL_ITEMS) begin
         add_random_group();
      end
      total_bytes = line_bytes.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (bytes_taken == total_bytes);
      wait (expected_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ video_line_group_decoder.f @@
hdl/vlgd_pkg.sv
hdl/vlgd_decode.sv
hdl/vlgd_expand.sv
hdl/video_line_group_decoder.sv
test/video_line_group_decoder_tb.sv
